FILE: rtl/cell_track_energy_accumulator_core_defines.svh
// Assertion macros used by the checker file of the hit accumulator.
`ifndef CELL_TRACK_ENERGY_ACCUMULATOR_CORE_DEFINES_SVH
`define CELL_TRACK_ENERGY_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and silent while rst is high.
`define CTEA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and silent while rst is high.
`define CTEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ctea_pkg.sv
// Shared types, codes and the saturating adder of the hit accumulator.
package ctea_pkg;

  typedef logic [35:0] key_t;
  typedef logic [31:0] sum_t;

  typedef struct packed {
    sum_t mip;
    sum_t em;
    sum_t had;
  } sums_t;

  // Controls from the sequencer to the hit store.
  typedef struct packed {
    logic key_rd;
    logic sum_rd;
    logic key_wr;
    logic sum_wr;
    logic sum_fresh;
  } store_ctrl_t;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [1:0] KIND_MIP  = 2'd0;
  localparam logic [1:0] KIND_EM   = 2'd1;
  localparam logic [1:0] KIND_HAD  = 2'd2;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

FILE: rtl/ctea_hit_store.sv
// Key and sum memories of all hit lists, with the saturating sum update.
module ctea_hit_store #(
  parameter int ADDR_W = 10
) (
  input  logic                  clk,
  input  ctea_pkg::store_ctrl_t ctrl,
  input  logic [ADDR_W-1:0]     key_rd_addr,
  input  logic [ADDR_W-1:0]     sum_rd_addr,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  ctea_pkg::key_t        wr_key,
  input  logic [23:0]           energy,
  input  logic [1:0]            kind,
  output ctea_pkg::key_t        key_rd_data,
  output ctea_pkg::sums_t       upd_sums
);

  localparam int DEPTH = 1 << ADDR_W;

  ctea_pkg::key_t  key_mem [DEPTH];
  ctea_pkg::sums_t sum_mem [DEPTH];
  ctea_pkg::sums_t sum_rd_data;
  ctea_pkg::sums_t sum_base;
  ctea_pkg::sum_t  step;

  always_ff @(posedge clk) begin
    if (ctrl.key_rd) begin
      key_rd_data <= key_mem[key_rd_addr];
    end
    if (ctrl.key_wr) begin
      key_mem[wr_addr] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_rd) begin
      sum_rd_data <= sum_mem[sum_rd_addr];
    end
    if (ctrl.sum_wr) begin
      sum_mem[wr_addr] <= upd_sums;
    end
  end

  // A fresh entry starts from zero sums; otherwise the read data is updated.
  always_comb begin
    sum_base = ctrl.sum_fresh ? '0 : sum_rd_data;
    step     = {8'b0, energy};
    upd_sums = sum_base;
    case (kind)
      ctea_pkg::KIND_MIP: upd_sums.mip = ctea_pkg::sat_add(sum_base.mip, step);
      ctea_pkg::KIND_EM:  upd_sums.em  = ctea_pkg::sat_add(sum_base.em, step);
      ctea_pkg::KIND_HAD: upd_sums.had = ctea_pkg::sat_add(sum_base.had, step);
      default:            upd_sums = sum_base;
    endcase
  end

endmodule

FILE: rtl/cell_track_energy_accumulator_core.sv
// Top level of the per-calorimeter cell and track energy hit accumulator.
//
//   Channel   Signals                                          Handshake
//   --------  -----------------------------------------------  ---------------------
//   command   mode calorimeter cell_first cell_second          start high, busy low
//             track_id energy_step energy_kind search_from
//   result    status entry_index mip_sum em_sum had_sum        done, one cycle only
//             entry_count
//
// A clear word, or an add word for a calorimeter beyond the configured count,
// is answered in the cycle after it is taken and leaves busy low. An add word
// that hits the last created entry passes S_FAST and S_UPD. Otherwise the key
// memory is searched one entry per cycle from search_from; the single read
// port of the key memory sets that pace. One word is worked on at a time,
// so a read never overlaps a pending write to the same entry.
// Reset is synchronous: it empties all lists and forgets the last cell, and the
// memories themselves are not cleared. The receiver cannot stall results.
module cell_track_energy_accumulator_core #(
  parameter int HIT_DEPTH        = 256,
  parameter int NUM_CALORIMETERS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [1:0]  calorimeter,
  input  logic [9:0]  cell_first,
  input  logic [9:0]  cell_second,
  input  logic [15:0] track_id,
  input  logic [23:0] energy_step,
  input  logic [1:0]  energy_kind,
  input  logic [8:0]  search_from,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  entry_index,
  output logic [31:0] mip_sum,
  output logic [31:0] em_sum,
  output logic [31:0] had_sum,
  output logic [8:0]  entry_count
);

  localparam int IDX_W  = $clog2(HIT_DEPTH);
  localparam int LEN_W  = $clog2(HIT_DEPTH + 1);
  localparam int CAL_W  = (NUM_CALORIMETERS > 1) ? $clog2(NUM_CALORIMETERS) : 1;
  localparam int ADDR_W = CAL_W + IDX_W;
  localparam int SIDX_W = (LEN_W > 9) ? LEN_W : 9;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(HIT_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FAST   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_UPD    = 4'b1000
  } state_t;

  state_t state;

  // List lengths, one per calorimeter, and the remembered last cell.
  logic [LEN_W-1:0] lengths [NUM_CALORIMETERS];
  logic             last_valid;
  logic [21:0]      last_cell;

  // Word being worked on.
  logic [CAL_W-1:0]  cal_q;
  logic [21:0]       cell_q;
  ctea_pkg::key_t    key_q;
  logic [23:0]       energy_q;
  logic [1:0]        kind_q;
  logic [8:0]        from_q;
  logic [LEN_W-1:0]  len_q;

  // Search walk: idx is the next entry to read, pend marks a read in flight.
  logic [SIDX_W-1:0] idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  slot_q;

  // Decoded input word.
  logic              accept;
  logic              cal_ok;
  logic [CAL_W-1:0]  cal_in;
  logic [LEN_W-1:0]  len_in;
  logic [LEN_W-1:0]  len_in_m1;
  logic [LEN_W-1:0]  len_q_m1;
  logic [21:0]       cell_in;
  logic              fast_ok;

  // Per-cycle decisions.
  logic              issue_fast;
  logic              go_search;
  logic              fast_hit;
  logic              search_hit;
  logic              search_more;
  logic              search_miss;
  logic              create;
  logic              full_drop;

  ctea_pkg::store_ctrl_t ctrl;
  logic [ADDR_W-1:0]     key_rd_addr;
  logic [ADDR_W-1:0]     sum_rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  ctea_pkg::key_t        key_rd_data;
  ctea_pkg::sums_t       upd_sums;

  // Result about to be registered.
  logic                  res_valid;
  logic [1:0]            res_status;
  logic [7:0]            res_index;
  ctea_pkg::sums_t       res_sums;
  logic [8:0]            res_count;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign cal_ok    = (32'(calorimeter) < NUM_CALORIMETERS);
  assign cal_in    = CAL_W'(calorimeter);
  assign len_in    = cal_ok ? lengths[cal_in] : '0;
  assign len_in_m1 = len_in - 1'b1;
  assign len_q_m1  = len_q - 1'b1;
  assign cell_in   = {calorimeter, cell_first, cell_second};

  // The last created entry is tried first when the word is for the same cell.
  assign fast_ok = last_valid && (last_cell == cell_in) && (len_in != '0);

  assign issue_fast = accept && (mode == ctea_pkg::MODE_ADD) && cal_ok && fast_ok;
  assign go_search  = accept && (mode == ctea_pkg::MODE_ADD) && cal_ok && !fast_ok;

  assign fast_hit    = (state == S_FAST) && (key_rd_data == key_q);
  assign search_hit  = (state == S_SEARCH) && pend && (key_rd_data == key_q);
  assign search_more = (idx < SIDX_W'(len_q));
  assign search_miss = (state == S_SEARCH) && !search_hit && !search_more;
  assign create      = search_miss && (len_q != LEN_FULL);
  assign full_drop   = search_miss && (len_q == LEN_FULL);

  always_comb begin
    ctrl.key_rd    = issue_fast ||
                     ((state == S_SEARCH) && !search_hit && search_more);
    ctrl.sum_rd    = fast_hit || search_hit;
    ctrl.key_wr    = create;
    ctrl.sum_wr    = create || (state == S_UPD);
    ctrl.sum_fresh = create;

    if (state == S_IDLE) begin
      key_rd_addr = {cal_in, len_in_m1[IDX_W-1:0]};
    end else begin
      key_rd_addr = {cal_q, idx[IDX_W-1:0]};
    end

    if (state == S_FAST) begin
      sum_rd_addr = {cal_q, len_q_m1[IDX_W-1:0]};
    end else begin
      sum_rd_addr = {cal_q, pend_idx};
    end

    if (state == S_UPD) begin
      wr_addr = {cal_q, slot_q};
    end else begin
      wr_addr = {cal_q, len_q[IDX_W-1:0]};
    end
  end

  // Result selection: clear, unknown calorimeter, full list, new entry, update.
  always_comb begin
    res_valid  = 1'b0;
    res_status = ctea_pkg::ST_ADDED;
    res_index  = '0;
    res_sums   = '0;
    res_count  = '0;
    if (accept && (mode == ctea_pkg::MODE_CLEAR)) begin
      res_valid  = 1'b1;
      res_status = ctea_pkg::ST_CLEARED;
    end else if (accept && !cal_ok) begin
      res_valid  = 1'b1;
      res_status = ctea_pkg::ST_FULL;
    end else if (full_drop) begin
      res_valid  = 1'b1;
      res_status = ctea_pkg::ST_FULL;
      res_count  = 9'(len_q);
    end else if (create) begin
      res_valid  = 1'b1;
      res_status = ctea_pkg::ST_NEW;
      res_index  = 8'(len_q);
      res_sums   = upd_sums;
      res_count  = 9'(len_q + 1'b1);
    end else if (state == S_UPD) begin
      res_valid  = 1'b1;
      res_status = ctea_pkg::ST_ADDED;
      res_index  = 8'(slot_q);
      res_sums   = upd_sums;
      res_count  = 9'(len_q);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      last_valid <= 1'b0;
      last_cell  <= '0;
      pend       <= 1'b0;
      for (int c = 0; c < NUM_CALORIMETERS; c++) begin
        lengths[c] <= '0;
      end
    end else begin
      done <= res_valid;
      case (state)
        S_IDLE: begin
          if (accept && (mode == ctea_pkg::MODE_CLEAR)) begin
            if (cal_ok) begin
              lengths[cal_in] <= '0;
            end
            last_valid <= 1'b0;
          end else if (issue_fast) begin
            state <= S_FAST;
          end else if (go_search) begin
            state <= S_SEARCH;
            pend  <= 1'b0;
          end
        end
        S_FAST: begin
          if (fast_hit) begin
            state <= S_UPD;
          end else begin
            state <= S_SEARCH;
            pend  <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (search_hit) begin
            state <= S_UPD;
          end else if (search_more) begin
            pend <= 1'b1;
          end else begin
            state <= S_IDLE;
            if (create) begin
              lengths[cal_q] <= len_q + 1'b1;
              last_cell      <= cell_q;
              last_valid     <= 1'b1;
            end
          end
        end
        S_UPD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cal_q    <= cal_in;
      cell_q   <= cell_in;
      key_q    <= {cell_first, cell_second, track_id};
      energy_q <= energy_step;
      kind_q   <= energy_kind;
      from_q   <= search_from;
      len_q    <= len_in;
      idx      <= SIDX_W'(search_from);
    end else if ((state == S_FAST) && !fast_hit) begin
      idx <= SIDX_W'(from_q);
    end else if ((state == S_SEARCH) && !search_hit && search_more) begin
      idx      <= idx + 1'b1;
      pend_idx <= idx[IDX_W-1:0];
    end
    if (fast_hit) begin
      slot_q <= len_q_m1[IDX_W-1:0];
    end else if (search_hit) begin
      slot_q <= pend_idx;
    end
    if (res_valid) begin
      status      <= res_status;
      entry_index <= res_index;
      mip_sum     <= res_sums.mip;
      em_sum      <= res_sums.em;
      had_sum     <= res_sums.had;
      entry_count <= res_count;
    end
  end

  ctea_hit_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk         (clk),
    .ctrl        (ctrl),
    .key_rd_addr (key_rd_addr),
    .sum_rd_addr (sum_rd_addr),
    .wr_addr     (wr_addr),
    .wr_key      (key_q),
    .energy      (energy_q),
    .kind        (kind_q),
    .key_rd_data (key_rd_data),
    .upd_sums    (upd_sums)
  );

endmodule

FILE: rtl/ctea_checker.sv
// Port-level checks of the hit accumulator and their bind to the top level.
`include "cell_track_energy_accumulator_core_defines.svh"

module ctea_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        mode,
  input logic        done,
  input logic [1:0]  status,
  input logic [7:0]  entry_index,
  input logic [31:0] mip_sum,
  input logic [31:0] em_sum,
  input logic [31:0] had_sum,
  input logic [8:0]  entry_count
);

  // A result is only shown once the word's work is over.
  `CTEA_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")

  // A clear word is answered in the next cycle.
  `CTEA_ASSERT_NEXT(a_clear_answer, start && !busy && mode == ctea_pkg::MODE_CLEAR, done && status == ctea_pkg::ST_CLEARED, "clear not answered")

  // An add word either starts work or is answered at once.
  `CTEA_ASSERT_NEXT(a_add_progress, start && !busy && mode == ctea_pkg::MODE_ADD, busy || done, "add word lost")

  // Dropped and clear results carry no entry and no sums.
  `CTEA_ASSERT_IMP(a_empty_result, done && (status == ctea_pkg::ST_CLEARED || status == ctea_pkg::ST_FULL), entry_index == 8'd0 && mip_sum == 32'd0 && em_sum == 32'd0 && had_sum == 32'd0, "nonzero payload on empty result")

  // A clear always leaves an empty list.
  `CTEA_ASSERT_IMP(a_clear_count, done && status == ctea_pkg::ST_CLEARED, entry_count == 9'd0, "clear left entries")

endmodule

bind cell_track_energy_accumulator_core ctea_checker u_ctea_checker (.*);
